[rtl/scfla_pkg.sv]
`default_nettype none

package scfla_pkg;

  // Field widths of the channels
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LIMIT_W    = 7;

  // Default geometry of the heap
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned HEAP_PAGES_DEF   = 64;

  // Page limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Payload size of each class
  localparam int unsigned PAYLOAD_SMALL  = 8;
  localparam int unsigned PAYLOAD_MEDIUM = 64;
  localparam int unsigned PAYLOAD_LARGE  = 512;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  // Size class codes, also the tag kept in a block header
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd2;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERSIZE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd3;

endpackage

`default_nettype wire

[rtl/scfla_req_if.sv]
`default_nettype none

interface scfla_req_if;
  logic                              valid;
  logic                              ready;
  logic [scfla_pkg::CMD_W-1:0]       command;
  logic [scfla_pkg::REQ_W-1:0]       request_bytes;
  logic [scfla_pkg::ADDR_W-1:0]      release_address;

  modport source (output valid, output command, output request_bytes,
                  output release_address, input ready);
  modport sink   (input valid, input command, input request_bytes,
                  input release_address, output ready);
endinterface

`default_nettype wire

[rtl/scfla_rsp_if.sv]
`default_nettype none

interface scfla_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [scfla_pkg::ADDR_W-1:0]      block_address;
  logic [scfla_pkg::CLS_W-1:0]       size_class;
  logic [scfla_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output block_address, output size_class,
                  output status, input ready);
  modport sink   (input valid, input block_address, input size_class,
                  input status, output ready);
endinterface

`default_nettype wire

[rtl/scfla_cfg_if.sv]
`default_nettype none

interface scfla_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [scfla_pkg::LIMIT_W-1:0]     page_limit;

  modport source (output valid, output page_limit, input ready);
  modport sink   (input valid, input page_limit, output ready);
endinterface

`default_nettype wire

[rtl/scfla_ram.sv]
`default_nettype none

module scfla_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/size_class_free_list_allocator.sv]
// Each accepted request passes from idle through RESP, POP or PUSH, which loads the result;
// an allocate that carves first walks all PAGE_BYTES/8 slots of the page (512 by default).
// Requests do not overlap: a new one waits in idle until the last has loaded its result.
// Reset: free lists empty, no page carved, page limit 64; no clearing pass: carving writes
// every slot of a page, and releases into pages not yet carved are refused by the fill mark.
`default_nettype none

module size_class_free_list_allocator #(
  parameter int unsigned PAGE_BYTES   = scfla_pkg::PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = scfla_pkg::HEADER_BYTES_DEF,
  parameter int unsigned HEAP_PAGES   = scfla_pkg::HEAP_PAGES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  scfla_req_if.sink  req_i,
  scfla_rsp_if.source rsp_o,
  scfla_cfg_if.sink  cfg_i
);

  localparam int unsigned HEAP_SIZE   = HEAP_PAGES * PAGE_BYTES;
  localparam int unsigned STORE_DEPTH = HEAP_SIZE / 8;
  localparam int unsigned PAGE_SLOTS  = PAGE_BYTES / 8;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned LINK_W      = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = LINK_W + scfla_pkg::CLS_W;
  localparam int unsigned PG_W        = $clog2(HEAP_PAGES + 1);
  localparam int unsigned SW          = $clog2(PAGE_SLOTS) + 2;
  localparam int unsigned STRIDE_S = (HEADER_BYTES + scfla_pkg::PAYLOAD_SMALL + 7) / 8;
  localparam int unsigned STRIDE_M = (HEADER_BYTES + scfla_pkg::PAYLOAD_MEDIUM + 7) / 8;
  localparam int unsigned STRIDE_L = (HEADER_BYTES + scfla_pkg::PAYLOAD_LARGE + 7) / 8;

  localparam int unsigned CLS_W    = scfla_pkg::CLS_W;
  localparam int unsigned ADDR_W   = scfla_pkg::ADDR_W;
  localparam int unsigned STATUS_W = scfla_pkg::STATUS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RESP  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_CARVE = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [CLS_W-1:0]                 cls_q, cls_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [SW-1:0]                    slot_q, slot_d;
  logic [SW-1:0]                    hdr_q, hdr_d;
  logic [LINK_W-1:0]                heads_q [3];
  logic [LINK_W-1:0]                heads_d [3];
  logic [PG_W-1:0]                  pages_q, pages_d;
  logic [LINK_W-1:0]                carved_q, carved_d;
  logic [scfla_pkg::LIMIT_W-1:0]    limit_q;
  logic [ADDR_W-1:0]                res_addr_q, res_addr_d;
  logic [CLS_W-1:0]                 res_cls_q, res_cls_d;
  logic [STATUS_W-1:0]              res_stat_q, res_stat_d;
  logic                             out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]                out_addr_q, out_addr_d;
  logic [CLS_W-1:0]                 out_cls_q, out_cls_d;
  logic [STATUS_W-1:0]              out_stat_q, out_stat_d;

  logic                             out_free;
  logic                             out_load;
  logic [ADDR_W-1:0]                load_addr;
  logic [CLS_W-1:0]                 load_cls;
  logic [STATUS_W-1:0]              load_stat;

  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic [ENTRY_W-1:0]               mem_wdata;
  logic                             mem_re;
  logic [IDX_W-1:0]                 mem_raddr;
  logic [ENTRY_W-1:0]               mem_rdata;
  logic [LINK_W-1:0]                rd_link;
  logic [CLS_W-1:0]                 rd_tag;

  logic                             head_we;
  logic [CLS_W-1:0]                 head_wsel;
  logic [LINK_W-1:0]                head_wdata;
  logic [CLS_W-1:0]                 head_sel;
  logic [LINK_W-1:0]                head_rd;

  logic [CLS_W-1:0]                 in_cls;
  logic                             in_oversize;
  logic                             can_carve;
  logic [31:0]                      rel_hdr;
  logic                             rel_bad;
  logic [IDX_W-1:0]                 rel_idx;
  logic                             rel_unused;
  logic [31:0]                      pop_addr;

  logic [SW-1:0]                    stride;
  logic [SW-1:0]                    hdr_end;
  logic [SW-1:0]                    hdr_next_end;
  logic                             is_hdr;
  logic                             has_next;
  logic [LINK_W-1:0]                link_next;
  logic                             slot_last;

  // Header store: next link in the low bits, class tag on top
  scfla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_link = mem_rdata[LINK_W-1:0];
  assign rd_tag  = mem_rdata[ENTRY_W-1 -: CLS_W];

  // Pick the smallest class that fits the request
  always_comb begin
    in_oversize = 1'b0;
    if (req_i.request_bytes <= scfla_pkg::REQ_W'(scfla_pkg::PAYLOAD_SMALL)) begin
      in_cls = scfla_pkg::CLS_SMALL;
    end else if (req_i.request_bytes <= scfla_pkg::REQ_W'(scfla_pkg::PAYLOAD_MEDIUM)) begin
      in_cls = scfla_pkg::CLS_MEDIUM;
    end else if (req_i.request_bytes <= scfla_pkg::REQ_W'(scfla_pkg::PAYLOAD_LARGE)) begin
      in_cls = scfla_pkg::CLS_LARGE;
    end else begin
      in_cls      = scfla_pkg::CLS_NONE;
      in_oversize = 1'b1;
    end
  end

  assign can_carve = (32'(pages_q) < 32'(limit_q)) && (32'(pages_q) < HEAP_PAGES);

  // Check a release address and locate its header slot
  assign rel_hdr    = 32'(req_i.release_address) - 32'(HEADER_BYTES);
  assign rel_bad    = (32'(req_i.release_address) < 32'(HEADER_BYTES)) ||
                      (rel_hdr >= HEAP_SIZE) || (rel_hdr[2:0] != 3'd0);
  assign rel_idx    = rel_hdr[IDX_W+2:3];
  assign rel_unused = 32'(rel_idx) >= 32'(carved_q);

  assign pop_addr = (32'(idx_q) << 3) + 32'(HEADER_BYTES);

  // Single read port on the list heads
  assign head_sel = (state_q == S_PUSH) ? rd_tag : in_cls;

  always_comb begin
    case (head_sel)
      scfla_pkg::CLS_SMALL:  head_rd = heads_q[0];
      scfla_pkg::CLS_MEDIUM: head_rd = heads_q[1];
      scfla_pkg::CLS_LARGE:  head_rd = heads_q[2];
      default:               head_rd = '0;
    endcase
  end

  // Carving: walk every slot of the page, linking block headers in order
  always_comb begin
    case (cls_q)
      scfla_pkg::CLS_SMALL:  stride = SW'(STRIDE_S);
      scfla_pkg::CLS_MEDIUM: stride = SW'(STRIDE_M);
      default:               stride = SW'(STRIDE_L);
    endcase
  end

  assign hdr_end      = hdr_q + stride;
  assign hdr_next_end = hdr_end + stride;
  assign is_hdr       = (slot_q == hdr_q) && (32'(hdr_end) <= PAGE_SLOTS);
  assign has_next     = 32'(hdr_next_end) <= PAGE_SLOTS;
  assign link_next    = carved_q + LINK_W'(hdr_end) + LINK_W'(1);
  assign slot_last    = (slot_q == SW'(PAGE_SLOTS - 1));

  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Sequencer: decode, read, then modify and write back; carve a page when a list is empty
  always_comb begin
    state_d    = state_q;
    cls_d      = cls_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    hdr_d      = hdr_q;
    pages_d    = pages_q;
    carved_d   = carved_q;
    res_addr_d = res_addr_q;
    res_cls_d  = res_cls_q;
    res_stat_d = res_stat_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = idx_q;
    head_we    = 1'b0;
    head_wsel  = cls_q;
    head_wdata = '0;
    out_load   = 1'b0;
    load_addr  = '0;
    load_cls   = scfla_pkg::CLS_NONE;
    load_stat  = scfla_pkg::STATUS_OK;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_addr_d = '0;
          res_cls_d  = scfla_pkg::CLS_NONE;
          res_stat_d = scfla_pkg::STATUS_OK;
          if (req_i.command == scfla_pkg::CMD_ALLOC) begin
            cls_d = in_cls;
            if (in_oversize) begin
              res_stat_d = scfla_pkg::STATUS_OVERSIZE;
              state_d    = S_RESP;
            end else if (head_rd != '0) begin
              idx_d     = IDX_W'(head_rd - LINK_W'(1));
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(head_rd - LINK_W'(1));
              state_d   = S_POP;
            end else if (can_carve) begin
              slot_d  = '0;
              hdr_d   = '0;
              state_d = S_CARVE;
            end else begin
              res_cls_d  = in_cls;
              res_stat_d = scfla_pkg::STATUS_EXHAUSTED;
              state_d    = S_RESP;
            end
          end else begin
            if (req_i.release_address == '0) begin
              state_d = S_RESP;
            end else if (rel_bad || rel_unused) begin
              res_stat_d = scfla_pkg::STATUS_BAD_RELEASE;
              state_d    = S_RESP;
            end else begin
              idx_d     = rel_idx;
              mem_re    = 1'b1;
              mem_raddr = rel_idx;
              state_d   = S_PUSH;
            end
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_addr = res_addr_q;
          load_cls  = res_cls_q;
          load_stat = res_stat_q;
          state_d   = S_IDLE;
        end
      end

      S_POP: begin
        if (out_free) begin
          head_we    = 1'b1;
          head_wsel  = cls_q;
          head_wdata = rd_link;
          mem_we     = 1'b1;
          mem_waddr  = idx_q;
          mem_wdata  = {cls_q, LINK_W'(0)};
          out_load   = 1'b1;
          load_addr  = pop_addr[ADDR_W-1:0];
          load_cls   = cls_q;
          load_stat  = scfla_pkg::STATUS_OK;
          state_d    = S_IDLE;
        end
      end

      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (rd_tag == scfla_pkg::CLS_NONE) begin
            load_stat = scfla_pkg::STATUS_BAD_RELEASE;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = idx_q;
            mem_wdata  = {scfla_pkg::CLS_NONE, head_rd};
            head_we    = 1'b1;
            head_wsel  = rd_tag;
            head_wdata = LINK_W'(idx_q) + LINK_W'(1);
            load_cls   = rd_tag;
          end
        end
      end

      S_CARVE: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(carved_q + LINK_W'(slot_q));
        mem_wdata = (is_hdr && has_next) ? {scfla_pkg::CLS_NONE, link_next} : '0;
        slot_d    = slot_q + SW'(1);
        if (is_hdr) begin
          hdr_d = hdr_end;
        end
        if (slot_last) begin
          head_we    = 1'b1;
          head_wsel  = cls_q;
          head_wdata = carved_q + LINK_W'(1);
          carved_d   = carved_q + LINK_W'(PAGE_SLOTS);
          pages_d    = pages_q + PG_W'(1);
          idx_d      = IDX_W'(carved_q);
          mem_re     = 1'b1;
          mem_raddr  = IDX_W'(carved_q);
          state_d    = S_POP;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Update the list heads
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      heads_d[i] = (head_we && head_wsel == CLS_W'(i + 1)) ? head_wdata : heads_q[i];
    end
  end

  // Output register: hold until taken, load a new result when free
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_addr_d  = out_addr_q;
    out_cls_d   = out_cls_q;
    out_stat_d  = out_stat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_addr_d  = load_addr;
      out_cls_d   = load_cls;
      out_stat_d  = load_stat;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.size_class    = out_cls_q;
  assign rsp_o.status        = out_stat_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pages_q     <= '0;
      carved_q    <= '0;
      limit_q     <= scfla_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pages_q     <= pages_d;
      carved_q    <= carved_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.page_limit;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cls_q      <= cls_d;
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    hdr_q      <= hdr_d;
    res_addr_q <= res_addr_d;
    res_cls_q  <= res_cls_d;
    res_stat_q <= res_stat_d;
    out_addr_q <= out_addr_d;
    out_cls_q  <= out_cls_d;
    out_stat_q <= out_stat_d;
  end

`ifndef NO_ASSERTIONS
  // Never carve beyond the heap
  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pages_q) <= HEAP_PAGES))
    else $error("page count beyond heap");

  a_carve_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CARVE) |-> (32'(pages_q) < HEAP_PAGES))
    else $error("carving with no page left");

  // A pop reads the header the class head points at
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |->
      ((cls_q == scfla_pkg::CLS_SMALL  && heads_q[0] == LINK_W'(idx_q) + LINK_W'(1)) ||
       (cls_q == scfla_pkg::CLS_MEDIUM && heads_q[1] == LINK_W'(idx_q) + LINK_W'(1)) ||
       (cls_q == scfla_pkg::CLS_LARGE  && heads_q[2] == LINK_W'(idx_q) + LINK_W'(1))))
    else $error("pop address differs from list head");

  // List heads stay within the carved region
  a_heads_carved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heads_q[0] <= carved_q) && (heads_q[1] <= carved_q) && (heads_q[2] <= carved_q))
    else $error("list head beyond carved pages");
`endif

endmodule

`default_nettype wire
